[src/sse_pkg.sv]
// Package with the word types and fixed widths of the shaker sort engine.
package sse_pkg;

   localparam int ELEM_W = 32;
   localparam int CMP_W  = 11;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic                     is_final;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] sorted_value;
      logic                     end_of_run;
      logic [CMP_W-1:0]         compare_total;
      logic                     overflowed;
   } rsp_type;

endpackage

[src/shaker_sort_engine.sv]
// Shaker sort engine: loads words into a local memory, sorts them with a
// bidirectional bubble sort over one compare-and-swap unit, then streams them out.
//
// Input words are loaded back to back while busy is low; a word that arrives
// with the store full is dropped and flagged. The word marked final starts the
// sort and busy stays high until the run has been streamed out. One
// compare-and-swap is done per cycle within a pass, against a memory with one
// read and one write port, and each pass also has a start, a first read and a
// closing write around its compares. The sorted words are then streamed out one
// word per cycle on rsp_strobe; the receiver cannot stall, so every strobe must
// be taken in its cycle.
module shaker_sort_engine
   import sse_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] P_ONE = AW'(1);
   localparam logic [AW-1:0] P_TWO = AW'(2);
   localparam logic [AW-1:0] P_TOP = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] F_ONE = CW'(1);
   localparam logic [CW-1:0] F_MAX = CW'(CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_BSTART = 10'b00_0000_0010,
      S_BLOAD  = 10'b00_0000_0100,
      S_BRUN   = 10'b00_0000_1000,
      S_BEND   = 10'b00_0001_0000,
      S_FSTART = 10'b00_0010_0000,
      S_FLOAD  = 10'b00_0100_0000,
      S_FRUN   = 10'b00_1000_0000,
      S_FEND   = 10'b01_0000_0000,
      S_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] left_ff, left_in;
   logic [AW-1:0] right_ff, right_in;
   logic [AW-1:0] swap_pos_ff, swap_pos_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic [CMP_W-1:0] cmp_cnt_ff, cmp_cnt_in;
   logic drop_ff, drop_in;
   logic done_ff, done_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic rsp_last_ff, rsp_last_in;
   logic signed [ELEM_W-1:0] carry_ff, carry_in;

   logic signed [ELEM_W-1:0] store [CAPACITY];
   logic signed [ELEM_W-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic signed [ELEM_W-1:0] mem_wd;

   logic full;
   logic accept;
   logic [AW-1:0] last_idx;
   logic fwd;
   logic signed [ELEM_W-1:0] lo_val, hi_val, keep_val, pass_val;
   logic swap;

   assign full     = (fill_ff == F_MAX);
   assign accept   = start && !busy;
   assign last_idx = AW'(fill_ff - F_ONE);

   // The carried word sits on the lower side in a forward pass and on the
   // upper side in a backward pass; the word that belongs at the carry
   // position is written back there and the other one moves on.
   assign fwd      = (state_ff == S_FRUN);
   assign lo_val   = fwd ? carry_ff : rd_data_ff;
   assign hi_val   = fwd ? rd_data_ff : carry_ff;
   assign swap     = (lo_val > hi_val);
   assign keep_val = swap ? rd_data_ff : carry_ff;
   assign pass_val = swap ? carry_ff : rd_data_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      swap_pos_in   = swap_pos_ff;
      ptr_in        = ptr_ff;
      emit_idx_in   = emit_idx_ff;
      cmp_cnt_in    = cmp_cnt_ff;
      drop_in       = drop_ff;
      done_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      carry_in      = carry_ff;
      rd_addr       = ptr_ff;
      mem_we        = 1'b0;
      mem_wa        = ptr_ff;
      mem_wd        = carry_ff;

      case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               fill_in    = '0;
               cmp_cnt_in = '0;
               drop_in    = 1'b0;
            end else if (accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  mem_we  = 1'b1;
                  mem_wa  = fill_ff[AW-1:0];
                  mem_wd  = req_data.element;
                  fill_in = fill_ff + F_ONE;
               end
               if (req_data.is_final) begin
                  left_in     = '0;
                  right_in    = full ? P_TOP : fill_ff[AW-1:0];
                  swap_pos_in = full ? P_TOP : fill_ff[AW-1:0];
                  emit_idx_in = '0;
                  state_in    = (fill_ff == '0) ? S_EMIT : S_BSTART;
               end
            end
         end
         S_BSTART: begin
            rd_addr  = right_ff;
            ptr_in   = right_ff;
            state_in = S_BLOAD;
         end
         S_BLOAD: begin
            carry_in = rd_data_ff;
            rd_addr  = ptr_ff - P_ONE;
            state_in = S_BRUN;
         end
         S_BRUN: begin
            mem_we     = 1'b1;
            mem_wd     = keep_val;
            carry_in   = pass_val;
            cmp_cnt_in = cmp_cnt_ff + CMP_W'(1);
            if (swap) begin
               swap_pos_in = ptr_ff;
            end
            ptr_in  = ptr_ff - P_ONE;
            rd_addr = ptr_ff - P_TWO;
            if (ptr_ff - P_ONE == left_ff) begin
               state_in = S_BEND;
            end
         end
         S_BEND: begin
            mem_we  = 1'b1;
            left_in = swap_pos_ff;
            if (swap_pos_ff < right_ff) begin
               state_in = S_FSTART;
            end else begin
               right_in = swap_pos_ff;
               state_in = S_EMIT;
            end
         end
         S_FSTART: begin
            rd_addr  = left_ff;
            ptr_in   = left_ff;
            state_in = S_FLOAD;
         end
         S_FLOAD: begin
            carry_in = rd_data_ff;
            rd_addr  = ptr_ff + P_ONE;
            state_in = S_FRUN;
         end
         S_FRUN: begin
            mem_we     = 1'b1;
            mem_wd     = keep_val;
            carry_in   = pass_val;
            cmp_cnt_in = cmp_cnt_ff + CMP_W'(1);
            if (swap) begin
               swap_pos_in = ptr_ff;
            end
            ptr_in  = ptr_ff + P_ONE;
            rd_addr = ptr_ff + P_TWO;
            if (ptr_ff + P_ONE == right_ff) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            mem_we   = 1'b1;
            right_in = swap_pos_ff;
            if (left_ff < swap_pos_ff) begin
               state_in = S_BSTART;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rd_addr       = emit_idx_ff;
            rsp_strobe_in = 1'b1;
            rsp_last_in   = (emit_idx_ff == last_idx);
            emit_idx_in   = emit_idx_ff + P_ONE;
            if (emit_idx_ff == last_idx) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The run totals stay valid through the cycle that shows the last word;
   // busy stays high in that cycle and the totals are cleared at its closing edge.
   assign busy = (state_ff != S_IDLE) || done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         swap_pos_ff   <= '0;
         ptr_ff        <= '0;
         emit_idx_ff   <= '0;
         cmp_cnt_ff    <= '0;
         drop_ff       <= 1'b0;
         done_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         swap_pos_ff   <= swap_pos_in;
         ptr_ff        <= ptr_in;
         emit_idx_ff   <= emit_idx_in;
         cmp_cnt_ff    <= cmp_cnt_in;
         drop_ff       <= drop_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store[rd_addr];
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.sorted_value  = rd_data_ff;
   assign rsp_data.end_of_run    = rsp_last_ff;
   assign rsp_data.compare_total = cmp_cnt_ff;
   assign rsp_data.overflowed    = drop_ff;

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word shown while the engine is idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.end_of_run |=> !rsp_strobe)
      else $error("word after the end of a run");

   a_pass_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BSTART || state_ff == S_FSTART) |-> left_ff < right_ff)
      else $error("sort pass started with empty bounds");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= F_MAX)
      else $error("fill count beyond capacity");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> fill_ff != '0)
      else $error("output phase with an empty store");

endmodule

[tb/sv/shaker_sort_engine_test.sv]
// Self-checking testbench for the shaker sort engine with a sort predictor.
module shaker_sort_engine_test;
   import sse_pkg::*;

   localparam int SORT_DEPTH   = 64;
   localparam int PHASE_WORDS  = 127;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 4000000;

   localparam logic signed [ELEM_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [ELEM_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

   typedef enum int {
      FILL_WIDE, FILL_NARROW, FILL_RISING, FILL_FALLING, FILL_FLAT, FILL_EDGES
   } fill_kind_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type req_backlog[$];
   rsp_type sorted_due[$];

   // Predictor state: the elements held for the current run.
   logic signed [ELEM_W-1:0] held_elem [SORT_DEPTH];
   int                       held_count = 0;
   logic                     held_dropped = 1'b0;

   int send_idle_pct;
   int error_count = 0;
   int cycle_count = 0;

   shaker_sort_engine #(
      .CAPACITY(SORT_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Stores one accepted word (or marks a drop when full) and, on the final word, sorts and queues the run.
   task automatic absorb_element(input req_type w);
      int                       lo;
      int                       hi;
      int                       last_swap;
      int                       j;
      logic [CMP_W-1:0]         compares;
      logic signed [ELEM_W-1:0] tmp;
      rsp_type                  r;
      if (held_count < SORT_DEPTH) begin
         held_elem[held_count] = w.element;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (w.is_final) begin
         compares  = '0;
         lo        = 0;
         hi        = held_count - 1;
         last_swap = hi;
         while (lo < hi) begin
            for (j = hi; j > lo; j--) begin
               if (held_elem[j-1] > held_elem[j]) begin
                  tmp            = held_elem[j-1];
                  held_elem[j-1] = held_elem[j];
                  held_elem[j]   = tmp;
                  last_swap      = j;
               end
               compares = compares + 1'b1;
            end
            lo = last_swap;
            for (j = lo; j < hi; j++) begin
               if (held_elem[j] > held_elem[j+1]) begin
                  tmp            = held_elem[j];
                  held_elem[j]   = held_elem[j+1];
                  held_elem[j+1] = tmp;
                  last_swap      = j;
               end
               compares = compares + 1'b1;
            end
            hi = last_swap;
         end
         for (j = 0; j < held_count; j++) begin
            r.sorted_value  = held_elem[j];
            r.end_of_run    = (j == held_count - 1);
            r.compare_total = compares;
            r.overflowed    = held_dropped;
            sorted_due.push_back(r);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic push_word(input logic signed [ELEM_W-1:0] value, input logic last);
      req_type w;
      w.element  = value;
      w.is_final = last;
      req_backlog.push_back(w);
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_value(input fill_kind_type kind,
                                                          input int idx,
                                                          input int base);
      logic signed [ELEM_W-1:0] v;
      case (kind)
         FILL_WIDE:    v = $urandom;
         FILL_NARROW:  v = $signed($urandom_range(0, 7)) - 4;
         FILL_RISING:  v = base + idx;
         FILL_FALLING: v = base - idx;
         FILL_FLAT:    v = base;
         default: begin
            case ($urandom_range(0, 4))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = 0;
               3:       v = -1;
               default: v = 1;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic push_run(input int n, input fill_kind_type kind);
      int base;
      int k;
      base = $signed($urandom_range(0, 2000)) - 1000;
      for (k = 0; k < n; k++) push_word(pick_value(kind, k, base), k == n - 1);
   endtask

   // Mostly short runs, with an occasional run around the store size.
   function automatic int pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 20);
      return $urandom_range(60, 70);
   endfunction

   // Driver: a word is taken at an edge with start high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) absorb_element(req_data);
         if (!start || !busy) begin
            if ($urandom_range(0, 99) < send_idle_pct) begin
               start <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               start    <= 1'b1;
               req_data <= req_backlog.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest expected word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected result word: sorted_value %0d", rsp_data.sorted_value);
            error_count++;
         end else begin
            want = sorted_due.pop_front();
            if (rsp_data.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want.sorted_value, rsp_data.sorted_value);
               error_count++;
            end
            if (rsp_data.end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %0d, actual %0d",
                      want.end_of_run, rsp_data.end_of_run);
               error_count++;
            end
            if (rsp_data.compare_total !== want.compare_total) begin
               $error("compare_total: expected %0d, actual %0d",
                      want.compare_total, rsp_data.compare_total);
               error_count++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0d, actual %0d",
                      want.overflowed, rsp_data.overflowed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int phase_start;
      int big_run [3];
      int idle_pct [3];
      big_run       = '{64, 66, 65};
      idle_pct      = '{7, 45, 0};
      reset         = 1'b1;
      send_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = idle_pct[phase];
         phase_start   = req_backlog.size();
         if (phase == 0) begin
            // Single-word runs at both extremes, then a two-word reversed pair.
            push_word(MOST_NEG, 1'b1);
            push_word(MOST_POS, 1'b1);
            push_word(MOST_POS, 1'b0);
            push_word(MOST_NEG, 1'b1);
            // Mixed extremes with duplicates.
            push_word(0, 1'b0);
            push_word(-1, 1'b0);
            push_word(1, 1'b0);
            push_word(MOST_NEG, 1'b0);
            push_word(MOST_POS, 1'b0);
            push_word(-1, 1'b0);
            push_word(32'sh5555_5555, 1'b0);
            push_word(32'shAAAA_AAAA, 1'b0);
            push_word(MOST_NEG, 1'b0);
            push_word(MOST_POS, 1'b1);
            // Already in order, then all equal.
            push_word(1, 1'b0);
            push_word(2, 1'b0);
            push_word(3, 1'b0);
            push_word(4, 1'b1);
            push_word(7, 1'b0);
            push_word(7, 1'b0);
            push_word(7, 1'b1);
         end
         // A full store, then overflow runs where the final word is dropped too.
         push_run(big_run[phase], FILL_WIDE);
         while (req_backlog.size() - phase_start < PHASE_WORDS)
            push_run(pick_run_length(), fill_kind_type'($urandom_range(0, 5)));
         while (req_backlog.size() != 0 || start || sorted_due.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && sorted_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/sse_pkg.sv
src/shaker_sort_engine.sv
tb/sv/shaker_sort_engine_test.sv
